@@ rtl/persistent_partner_filter_unit_macros.svh @@
// Assertion helpers for the checker file.
`ifndef PERSISTENT_PARTNER_FILTER_UNIT_MACROS_SVH
`define PERSISTENT_PARTNER_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PPF_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define PPF_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ppf_pkg.sv @@
`default_nettype none
package ppf_pkg;

  localparam int COUNT_W = 16;
  localparam int NEED_W  = 33;
  localparam int OUT_W   = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CFG_SNAPSHOT_COUNT = 2'd0;
  localparam logic [1:0] CFG_FRACTION_Q16   = 2'd1;
  localparam logic [1:0] CFG_NEWTON_ON      = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic record;   // a partner tag is presented this cycle
    logic hit_any;  // some cell already holds that tag
    logic shift;    // every cell takes its right neighbor's entry
    logic clear;    // drop all entries
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/ppf_cell.sv @@
`default_nettype none
module ppf_cell #(
  parameter int TW = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ppf_pkg::cell_ctl_t            ctl,
  input  wire logic [TW-1:0]                 rec_tag,
  input  wire logic                          prev_used,
  input  wire logic                          next_used,
  input  wire logic [TW-1:0]                 next_tag,
  input  wire logic [ppf_pkg::COUNT_W-1:0]   next_count,
  input  wire logic [TW-1:0]                 own_tag,
  input  wire logic [ppf_pkg::NEED_W-1:0]    need,
  input  wire logic                          newton,
  output logic                               used,
  output logic [TW-1:0]                      tag,
  output logic [ppf_pkg::COUNT_W-1:0]        count,
  output logic                               hit,
  output logic                               keep
);

  logic insert;

  // A new tag lands in the first free cell: this one is free and its left neighbor is taken.
  assign hit    = used && (tag == rec_tag);
  assign insert = ctl.record && !ctl.hit_any && !used && prev_used;
  assign keep   = used
               && ({1'b0, count, 16'h0000} >= need)
               && !(newton && (own_tag > tag));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.clear) begin
      used <= 1'b0;
    end else if (ctl.shift) begin
      used <= next_used;
    end else if (insert) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tag   <= next_tag;
      count <= next_count;
    end else if (ctl.record && hit) begin
      if (count != ppf_pkg::COUNT_MAX) begin
        count <= count + 1'b1;
      end
    end else if (insert) begin
      tag   <= rec_tag;
      count <= ppf_pkg::COUNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/persistent_partner_filter_unit.sv @@
// Throughput: one input item per cycle while an atom's partners stream in.
// The last item of an atom starts an emission pass over the row, one cell
// consumed per cycle and stretched by any output stall; input waits during the pass.
// After the last item is accepted, the emit state skips each leading partner in the
// row that fails the threshold and then loads the first result into the output register.
// Reset (rst, synchronous, active high) empties the row, clears the overflow flag,
// drops any pending result and loads the register defaults 1, 32768 and 1.
`default_nettype none
module persistent_partner_filter_unit #(
  parameter int MAX_PARTNERS = 8,
  parameter int TAG_BITS     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] partner_id, [63:32] own_tag
  input  wire logic [0:0]  s_axis_tuser,   // [0] has_partner
  input  wire logic        s_axis_tlast,   // last_of_atom
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] kept_partner
  output logic [1:0]       m_axis_tuser,   // [0] kept_valid, [1] table_overflow
  output logic             m_axis_tlast,   // last_result
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  // Tags are held at TAG_BITS, but never wider than the 32-bit fields they arrive in.
  localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;

  // Configuration registers, to be written only while idle (the block does not check).
  // The threshold product is registered so the 17 x 16 multiply stands alone between flops.
  logic [15:0]                    snapshot_count;
  logic [16:0]                    fraction_q16;
  logic                           newton_on;
  logic [ppf_pkg::NEED_W-1:0]     need;

  always_ff @(posedge clk) begin
    if (rst) begin
      snapshot_count <= 16'd1;
      fraction_q16   <= 17'd32768;
      newton_on      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ppf_pkg::CFG_SNAPSHOT_COUNT: snapshot_count <= cfg_data[15:0];
        ppf_pkg::CFG_FRACTION_Q16:   fraction_q16   <= cfg_data;
        ppf_pkg::CFG_NEWTON_ON:      newton_on      <= cfg_data[0];
        default:                     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    need <= ppf_pkg::NEED_W'(fraction_q16) * ppf_pkg::NEED_W'(snapshot_count);
  end

  // The row of partner cells. Cells fill from the left, so the used bits form a
  // prefix and the first free cell is found by looking at the left neighbor.
  // During emission the row shifts left by one cell each cycle unless a kept partner
  // waits on a busy output register, and cell 0 is the candidate for output.
  ppf_pkg::cell_ctl_t             ctl;
  logic [TW-1:0]                  rec_tag;
  logic [TW-1:0]                  own_tag;
  logic [MAX_PARTNERS-1:0]        used_vec;
  logic [MAX_PARTNERS-1:0]        hit_vec;
  logic [MAX_PARTNERS-1:0]        keep_vec;
  logic [TW-1:0]                  tag_arr   [MAX_PARTNERS];
  logic [ppf_pkg::COUNT_W-1:0]    count_arr [MAX_PARTNERS];

  assign rec_tag = s_axis_tdata[TW-1:0];

  for (genvar i = 0; i < MAX_PARTNERS; i++) begin : g_cell
    logic                         prev_used;
    logic                         next_used;
    logic [TW-1:0]                next_tag;
    logic [ppf_pkg::COUNT_W-1:0]  next_count;

    if (i == 0) begin : g_head
      assign prev_used = 1'b1;
    end else begin : g_body
      assign prev_used = used_vec[i-1];
    end

    if (i == MAX_PARTNERS - 1) begin : g_tail
      assign next_used  = 1'b0;
      assign next_tag   = '0;
      assign next_count = '0;
    end else begin : g_link
      assign next_used  = used_vec[i+1];
      assign next_tag   = tag_arr[i+1];
      assign next_count = count_arr[i+1];
    end

    ppf_cell #(
      .TW (TW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .rec_tag    (rec_tag),
      .prev_used  (prev_used),
      .next_used  (next_used),
      .next_tag   (next_tag),
      .next_count (next_count),
      .own_tag    (own_tag),
      .need       (need),
      .newton     (newton_on),
      .used       (used_vec[i]),
      .tag        (tag_arr[i]),
      .count      (count_arr[i]),
      .hit        (hit_vec[i]),
      .keep       (keep_vec[i])
    );
  end

  // Control: accept items while idle, then walk the row until the last kept
  // partner (or the empty marker) has been loaded into the output register.
  ppf_pkg::state_t state;
  ppf_pkg::state_t state_next;
  logic            accept;
  logic            out_free;
  logic            rest_keep;
  logic            table_full;
  logic            overflow_seen;
  logic            load;
  logic            load_valid;
  logic            load_last;

  assign s_axis_tready = (state == ppf_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign rest_keep     = |(keep_vec >> 1);
  assign table_full    = used_vec[MAX_PARTNERS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl.record  = accept && s_axis_tuser[0];
    ctl.hit_any = |hit_vec;
    ctl.shift   = 1'b0;
    ctl.clear   = 1'b0;
    load        = 1'b0;
    load_valid  = 1'b0;
    load_last   = 1'b0;
    case (state)
      ppf_pkg::ST_IDLE: begin
        if (accept && s_axis_tlast) begin
          state_next = ppf_pkg::ST_EMIT;
        end
      end
      ppf_pkg::ST_EMIT: begin
        if (keep_vec[0]) begin
          // Cell 0 holds a kept partner; it is the final one when nothing
          // further down the row passes.
          if (out_free) begin
            load       = 1'b1;
            load_valid = 1'b1;
            load_last  = !rest_keep;
            ctl.shift  = 1'b1;
            if (!rest_keep) begin
              ctl.clear  = 1'b1;
              state_next = ppf_pkg::ST_IDLE;
            end
          end
        end else if (rest_keep) begin
          ctl.shift = 1'b1;
        end else if (out_free) begin
          // Reaching here means nothing was kept for this atom: send the empty marker.
          load       = 1'b1;
          load_last  = 1'b1;
          ctl.clear  = 1'b1;
          state_next = ppf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppf_pkg::ST_IDLE;
      end
    endcase
  end

  // The atom's own tag is taken from its last item. Overflow marks a distinct
  // partner that found the row full; it clears with the row.
  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      own_tag <= s_axis_tdata[32 +: TW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (ctl.clear) begin
      overflow_seen <= 1'b0;
    end else if (ctl.record && !ctl.hit_any && table_full) begin
      overflow_seen <= 1'b1;
    end
  end

  // Output register. It parts the row from the result stream, so the next atom
  // can start while the final item of this one still waits to be taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= load_valid ? ppf_pkg::OUT_W'(tag_arr[0]) : '0;
      m_axis_tuser <= {overflow_seen, load_valid};
      m_axis_tlast <= load_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ppf_checker.sv @@
`default_nettype none
`include "persistent_partner_filter_unit_macros.svh"
module ppf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled result stays valid and keeps its data and last flag.
  `PPF_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // The empty marker is always the only, and so the final, item of its atom.
  `PPF_ASSERT_NOW(a_marker_last, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "empty marker not marked last")

  // The empty marker carries no partner tag.
  `PPF_ASSERT_NOW(a_marker_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 32'd0, "empty marker carries data")

  // Reset drops any pending result.
  `PPF_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid, "result valid after reset")

endmodule

bind persistent_partner_filter_unit ppf_checker u_ppf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
